[rtl/xor_delta_bit_gap_encoder_core_assert.svh]
// Assertion macros for the XOR-delta bit-gap encoder checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef XOR_DELTA_BIT_GAP_ENCODER_CORE_ASSERT_SVH
`define XOR_DELTA_BIT_GAP_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define XDBG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define XDBG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/xdbg_pkg.sv]
// Shared types and constants for the XOR-delta bit-gap encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package xdbg_pkg;

  localparam int WordW  = 32;
  localparam int CntW   = $clog2(WordW);
  localparam int DistW  = $clog2(WordW) + 1;
  localparam int CodeW  = 3;
  localparam int ExtraW = 5;

  localparam logic [CodeW-1:0] EscapeCode = 3'd7;
  localparam logic [CodeW-1:0] TermCode   = 3'd0;
  localparam logic [DistW-1:0] EscapeDist = 6'd7;
  localparam logic [CntW-1:0]  LastBit    = 5'd31;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             first;
  } xdbg_item_t;

  typedef struct packed {
    logic [CodeW-1:0]  gap_code;
    logic              has_extra;
    logic [ExtraW-1:0] extra_value;
    logic              last;
  } xdbg_sym_t;

  typedef enum logic [1:0] {
    XDBG_IDLE,
    XDBG_SCAN,
    XDBG_TERM
  } xdbg_state_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic emit_sym;
    logic emit_term;
  } xdbg_cmd_t;

  typedef struct packed {
    logic bit_set;
    logic scan_end;
    logic out_busy;
  } xdbg_sts_t;

endpackage

`default_nettype wire

[rtl/xdbg_ctrl.sv]
// Controller state machine: idle, bit scan, terminator.
// Depends on xdbg_pkg; drives commands to xdbg_dpath.
`default_nettype none

module xdbg_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  xdbg_pkg::xdbg_sts_t sts,
  output xdbg_pkg::xdbg_cmd_t cmd
);

  xdbg_pkg::xdbg_state_t state;
  xdbg_pkg::xdbg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xdbg_pkg::XDBG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      xdbg_pkg::XDBG_IDLE: begin
        if (item_valid) state_next = xdbg_pkg::XDBG_SCAN;
      end
      xdbg_pkg::XDBG_SCAN: begin
        if ((!sts.bit_set || !sts.out_busy) && sts.scan_end) begin
          state_next = xdbg_pkg::XDBG_TERM;
        end
      end
      xdbg_pkg::XDBG_TERM: begin
        if (!sts.out_busy) state_next = xdbg_pkg::XDBG_IDLE;
      end
      default: state_next = xdbg_pkg::XDBG_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      xdbg_pkg::XDBG_IDLE: begin
        item_stall = 1'b0;
        cmd.load   = item_valid;
      end
      xdbg_pkg::XDBG_SCAN: begin
        // a clear bit never waits; a set bit waits for the output register
        cmd.advance  = !sts.bit_set || !sts.out_busy;
        cmd.emit_sym = sts.bit_set && !sts.out_busy;
      end
      xdbg_pkg::XDBG_TERM: begin
        cmd.emit_term = !sts.out_busy;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/xdbg_dpath.sv]
// Datapath: previous word, delta shifter, gap counter and output register.
// Depends on xdbg_pkg; steered by xdbg_ctrl.
`default_nettype none

module xdbg_dpath (
  input  wire                  clk,
  input  wire                  rst,
  input  xdbg_pkg::xdbg_item_t item,
  output logic                 sym_valid,
  input  wire                  sym_stall,
  output xdbg_pkg::xdbg_sym_t  sym,
  input  xdbg_pkg::xdbg_cmd_t  cmd,
  output xdbg_pkg::xdbg_sts_t  sts
);

  logic [xdbg_pkg::WordW-1:0] prev_word;
  logic [xdbg_pkg::WordW-1:0] delta;
  logic [xdbg_pkg::CntW-1:0]  bit_cnt;
  logic [xdbg_pkg::DistW-1:0] gap_len;
  xdbg_pkg::xdbg_sym_t        sym_next;
  logic [xdbg_pkg::DistW-1:0] extra_full;

  assign sts.bit_set  = delta[0];
  assign sts.scan_end = (bit_cnt == xdbg_pkg::LastBit);
  assign sts.out_busy = sym_valid && sym_stall;

  assign extra_full = gap_len - xdbg_pkg::EscapeDist;

  always_comb begin
    sym_next = '0;
    if (cmd.emit_term) begin
      sym_next.gap_code = xdbg_pkg::TermCode;
      sym_next.last     = 1'b1;
    end else if (gap_len >= xdbg_pkg::EscapeDist) begin
      sym_next.gap_code    = xdbg_pkg::EscapeCode;
      sym_next.has_extra   = 1'b1;
      sym_next.extra_value = extra_full[xdbg_pkg::ExtraW-1:0];
    end else begin
      sym_next.gap_code = gap_len[xdbg_pkg::CodeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_word <= '0;
    end else if (cmd.load) begin
      prev_word <= item.word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      delta   <= item.first ? item.word : (item.word ^ prev_word);
      bit_cnt <= '0;
      gap_len <= xdbg_pkg::DistW'(1);
    end else if (cmd.advance) begin
      delta   <= delta >> 1;
      bit_cnt <= bit_cnt + xdbg_pkg::CntW'(1);
      // restart the gap after a set bit
      gap_len <= delta[0] ? xdbg_pkg::DistW'(1) : gap_len + xdbg_pkg::DistW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (cmd.emit_sym || cmd.emit_term) begin
      sym_valid <= 1'b1;
    end else if (!sym_stall) begin
      sym_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sym || cmd.emit_term) begin
      sym <= sym_next;
    end
  end

endmodule

`default_nettype wire

[rtl/xor_delta_bit_gap_encoder_core.sv]
// XOR-delta bit-gap encoder, top level: controller plus datapath.
// Each set delta bit yields a gap symbol in the output register, and the
// terminator follows the last bit. A new word is taken only in idle; each word
// passes through the accept, 32 one-bit scan steps and the terminator, and a set
// bit or the terminator waits while the output register holds a stalled symbol.
// Reset (rst, synchronous) returns to idle, empties the output, clears history.
`default_nettype none

module xor_delta_bit_gap_encoder_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_stall,
  input  xdbg_pkg::xdbg_item_t item,
  output logic                 sym_valid,
  input  wire                  sym_stall,
  output xdbg_pkg::xdbg_sym_t  sym
);

  xdbg_pkg::xdbg_cmd_t cmd;
  xdbg_pkg::xdbg_sts_t sts;

  xdbg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  xdbg_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .sym       (sym),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

[rtl/xdbg_checker.sv]
// Port-level checker for the XOR-delta bit-gap encoder, bound to the top.
// Depends on xdbg_pkg and xor_delta_bit_gap_encoder_core_assert.svh.
`default_nettype none
`include "xor_delta_bit_gap_encoder_core_assert.svh"

module xdbg_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  item_valid,
  input wire                  item_stall,
  input xdbg_pkg::xdbg_item_t item,
  input wire                  sym_valid,
  input wire                  sym_stall,
  input xdbg_pkg::xdbg_sym_t  sym
);

  logic item_take;
  logic req_wait;
  logic sym_wait;
  logic esc_code;
  logic sym_clean;
  logic clean_ok;

  assign item_take = item_valid && !item_stall;
  assign req_wait  = item_valid && item_stall;
  assign sym_wait  = sym_valid && sym_stall;
  assign esc_code  = (sym.gap_code == xdbg_pkg::EscapeCode);
  // the terminator and plain codes carry no extra bits
  assign sym_clean = sym_valid && (sym.last || !sym.has_extra);
  assign clean_ok  = (sym.extra_value == '0) &&
                     (!sym.last || (sym.gap_code == xdbg_pkg::TermCode && !sym.has_extra));

  `XDBG_ASSERT_NXT(a_req_hold, req_wait, item_valid && $stable(item), "stalled request changed")
  `XDBG_ASSERT_NXT(a_sym_hold, sym_wait, sym_valid && $stable(sym), "stalled symbol changed")
  `XDBG_ASSERT_NXT(a_busy_after_req, item_take, item_stall, "request accepted while scanning")
  `XDBG_ASSERT_IMP(a_escape_extra, sym_valid, sym.has_extra == esc_code, "extra flag off escape")
  `XDBG_ASSERT_IMP(a_term_clean, sym_clean, clean_ok, "terminator or plain code carries extra")

endmodule

bind xor_delta_bit_gap_encoder_core xdbg_checker u_xdbg_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_stall (item_stall),
  .item       (item),
  .sym_valid  (sym_valid),
  .sym_stall  (sym_stall),
  .sym        (sym)
);

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for xor_delta_bit_gap_encoder_core: random and directed
// words go in, every gap symbol is compared with a predicted symbol stream.
// Depends on xdbg_pkg and the core RTL only.

module tb_top;

  localparam int NumRandom  = 210;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 400;
  localparam int SettleCyc  = 40;

  typedef struct {
    xdbg_pkg::xdbg_item_t item;
    bit                   drain;  // wait for every pending symbol before offering
  } word_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  xdbg_pkg::xdbg_item_t in_item = '0;
  logic                 sym_valid;
  logic                 sym_stall = 1'b0;
  xdbg_pkg::xdbg_sym_t  out_sym;

  word_req_t           word_reqs[$];
  xdbg_pkg::xdbg_sym_t sym_expected[$];
  logic [31:0]         last_word = '0;

  int unsigned cycle_cnt    = 0;
  int unsigned words_sent   = 0;
  int unsigned firsts_sent  = 0;
  int unsigned syms_seen    = 0;
  int unsigned escapes_pred = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  logic        calm;

  xor_delta_bit_gap_encoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (in_item),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .sym       (out_sym)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // No random idling on either side inside this window.
  assign calm = (cycle_cnt >= 2500) && (cycle_cnt < 5500);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d symbols still pending", cycle_cnt,
               sym_expected.size());
      $display("xor_delta_bit_gap_encoder_core verification failed");
      $finish;
    end
  end

  // Predict the symbol stream of one accepted word and advance the history.
  task automatic encode_word(input xdbg_pkg::xdbg_item_t it);
    logic [31:0]         delta;
    int unsigned         gap_start;
    int unsigned         gap_len;
    xdbg_pkg::xdbg_sym_t s;
    delta     = it.first ? it.word : (it.word ^ last_word);
    last_word = it.word;
    gap_start = 0;
    for (int p = 1; p <= xdbg_pkg::WordW; p++) begin
      if (delta[p-1]) begin
        gap_len = p - gap_start;
        s       = '0;
        if (gap_len >= xdbg_pkg::EscapeDist) begin
          s.gap_code    = xdbg_pkg::EscapeCode;
          s.has_extra   = 1'b1;
          s.extra_value = xdbg_pkg::ExtraW'(gap_len - xdbg_pkg::EscapeDist);
          escapes_pred++;
        end else begin
          s.gap_code = xdbg_pkg::CodeW'(gap_len);
        end
        sym_expected = {sym_expected, s};
        gap_start = p;
      end
    end
    s          = '0;
    s.gap_code = xdbg_pkg::TermCode;
    s.last     = 1'b1;
    sym_expected = {sym_expected, s};
  endtask

  function automatic logic [31:0] pick_word(input logic [31:0] prev);
    logic [31:0] w;
    case ($urandom_range(9))
      0: w = prev;
      1: w = prev ^ (32'd1 << $urandom_range(31));
      2: w = $urandom & $urandom & $urandom;
      3: w = ~($urandom & $urandom & $urandom);
      4: w = prev ^ ($urandom & $urandom & $urandom & $urandom);
      5: w = 32'd1 << $urandom_range(31);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic word_req_t mk_req(input logic [31:0] w, input logic f, input bit d);
    word_req_t r;
    r.item.word  = w;
    r.item.first = f;
    r.drain      = d;
    return r;
  endfunction

  // Append one request to the pending queue.
  task automatic queue_req(input logic [31:0] w, input logic f, input bit d);
    word_reqs = {word_reqs, mk_req(w, f, d)};
  endtask

  // Driver: offer queued requests, hold each one until it is taken.
  always @(posedge clk) begin
    logic nxt_valid;
    bit   go;
    word_req_t req;
    nxt_valid = item_valid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        encode_word(in_item);
        words_sent++;
        if (in_item.first) firsts_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && word_reqs.size() != 0) begin
        go = 1'b1;
        if (word_reqs[0].drain && sym_expected.size() != 0) go = 1'b0;
        else if (!calm && $urandom_range(99) < 15) go = 1'b0;
        if (go) begin
          req       = word_reqs.pop_front();
          in_item   <= req.item;
          nxt_valid = 1'b1;
        end
      end
    end
    item_valid <= nxt_valid;
  end

  // Monitor: check each taken symbol, drive the output stall.
  always @(posedge clk) begin
    xdbg_pkg::xdbg_sym_t want;
    logic                nxt_stall;
    if (!rst && sym_valid && !sym_stall) begin
      syms_seen++;
      if (sym_expected.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected symbol code=%0d extra=%0d/%0d last=%0d", out_sym.gap_code,
                   out_sym.has_extra, out_sym.extra_value, out_sym.last);
      end else begin
        want = sym_expected.pop_front();
        if (out_sym.gap_code !== want.gap_code || out_sym.has_extra !== want.has_extra ||
            out_sym.extra_value !== want.extra_value || out_sym.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("symbol %0d: exp code=%0d extra=%0d/%0d last=%0d, %s",
                     syms_seen, want.gap_code, want.has_extra, want.extra_value, want.last,
                     $sformatf("got code=%0d extra=%0d/%0d last=%0d", out_sym.gap_code,
                               out_sym.has_extra, out_sym.extra_value, out_sym.last));
        end
      end
    end
    if (rst) begin
      nxt_stall = 1'b0;
    end else if (hold_left != 0) begin
      nxt_stall = 1'b1;
      hold_left--;
    end else if (!hold_done && syms_seen >= 400) begin
      // long back-pressure while the sender keeps offering
      hold_done = 1'b1;
      hold_left = HoldCycles;
      nxt_stall = 1'b1;
    end else begin
      nxt_stall = !calm && ($urandom_range(99) < 15);
    end
    sym_stall <= nxt_stall;
  end

  initial begin
    logic [31:0] gen_prev;
    logic [31:0] w;
    logic        f;
    int          seq_len;
    int          made;

    // unmarked word right after reset: history is zero
    queue_req(32'h1234_5678, 1'b0, 1'b0);
    queue_req(32'h0000_0000, 1'b1, 1'b0);
    queue_req(32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_req(32'hFFFF_FFFF, 1'b0, 1'b0);  // zero delta
    queue_req(32'h8000_0000, 1'b1, 1'b0);  // longest gap
    queue_req(32'h0000_0001, 1'b1, 1'b0);
    queue_req(32'h0000_0020, 1'b1, 1'b0);  // gap 6, no escape
    queue_req(32'h0000_0040, 1'b1, 1'b0);  // gap 7, escape with zero
    queue_req(32'h8000_0001, 1'b1, 1'b0);
    queue_req(32'hAAAA_AAAA, 1'b1, 1'b0);
    queue_req(32'h5555_5555, 1'b0, 1'b0);
    queue_req(32'h0101_0101, 1'b1, 1'b0);
    queue_req(32'h1020_4081, 1'b0, 1'b0);
    queue_req(32'h1020_4081, 1'b0, 1'b0);
    queue_req(32'hFFFF_0000, 1'b0, 1'b0);
    queue_req(32'h0000_FFFF, 1'b1, 1'b0);
    gen_prev = 32'h0000_FFFF;

    // random part: runs that open with a first word, with a little noise
    made = 0;
    while (made < NumRandom) begin
      seq_len = $urandom_range(12, 1);
      for (int k = 0; k < seq_len && made < NumRandom; k++) begin
        w = pick_word(gen_prev);
        if (k == 0) f = ($urandom_range(9) != 0);
        else        f = ($urandom_range(19) == 0);
        queue_req(w, f, made == 120);
        gen_prev = w;
        made++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (word_reqs.size() != 0 || item_valid) @(posedge clk);
    while (sym_expected.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);

    $display("ran %0d words (%0d marked first), %0d symbols checked, %0d escapes",
             words_sent, firsts_sent, syms_seen, escapes_pred);
    $display("mismatches: %0d, leftover symbols: %0d", mismatch_cnt, sym_expected.size());
    if (mismatch_cnt == 0 && sym_expected.size() == 0) begin
      $display("xor_delta_bit_gap_encoder_core verification clean");
    end else begin
      $display("xor_delta_bit_gap_encoder_core verification failed");
    end
    $finish;
  end

endmodule
